/* design/msh_pkg.sv */
// shared constants and types for the mid/side amplitude histogram
package msh_pkg;

    localparam int unsigned BINS      = 30;
    localparam int unsigned BIN_IDX_W = $clog2(BINS);
    localparam int unsigned BIN_W     = 65535 / BINS;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned FIELD_W   = 5;
    localparam int unsigned COUNT_W   = 32;

    // exact floor division of a 16-bit value by BIN_W through a reciprocal
    localparam int unsigned RECIP_SHIFT = SAMPLE_W + $clog2(BIN_W);
    localparam int unsigned RECIP_W     = SAMPLE_W + 1;
    localparam int unsigned PROD_W      = SAMPLE_W + RECIP_W;
    localparam longint unsigned RECIP   =
        ((64'd1 << RECIP_SHIFT) + 64'(BIN_W) - 64'd1) / 64'(BIN_W);

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 80;

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIN,
        ST_RMW
    } state_t;

endpackage

/* design/msh_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module msh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/mid_side_histogram.sv */
// mid/side amplitude histogram: bin mapping, count memories and result register
//
//  channel | dir | tdata fields (lsb first)                           | tuser
//  s_      | in  | left_sample 16, right_sample 16, read_bin 5, pad 3 | mode
//  m_      | out | mid_bin 5, side_bin 5, mid_count 32, side_count 32  | -
//
// each item runs in order through: accept and multiply, bin select and memory read,
// count update and write back; the memory read is registered, hence its own step
// counts stay in two memories of BINS words; reset clears per-bin valid bits,
// an invalid bin reads as zero, so no clearing pass is needed
// a waiting result does not block the next transfer; the update step waits
// only while the result register is still full
module mid_side_histogram (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // left_sample, right_sample, read_bin, zero pad
    input  logic        s_tuser,   // mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // mid_bin, side_bin, mid_count, side_count, zero pad
);

    localparam int unsigned IW = msh_pkg::BIN_IDX_W;
    localparam int unsigned CW = msh_pkg::COUNT_W;
    localparam int unsigned PW = msh_pkg::PROD_W;

    msh_pkg::state_t state_reg, state_next;

    logic                 s_xfer;
    logic                 out_free;
    logic                 wr_en;

    logic signed [16:0]   mid_sum, side_sum;
    logic signed [16:0]   mid_rnd, side_rnd;
    logic signed [16:0]   mid_half, side_half;
    logic [15:0]          mid_off, side_off;
    logic [msh_pkg::RECIP_W-1:0] recip;

    logic                 mode_reg;
    logic [PW-1:0]        mid_prod_reg, side_prod_reg;
    logic [IW-1:0]        rbin_reg;
    logic [4:0]           rbin_in;

    logic [PW-1:0]        mid_quo, side_quo;
    logic [IW-1:0]        mid_idx_c, side_idx_c;
    logic [IW-1:0]        mid_idx_reg, side_idx_reg;

    logic [msh_pkg::BINS-1:0] mid_vld_reg, side_vld_reg;
    logic                 mid_hit_reg, side_hit_reg;

    logic [CW-1:0]        mid_rd, side_rd;
    logic [CW-1:0]        mid_cur, side_cur;
    logic [CW-1:0]        mid_new, side_new;

    logic                 m_tvalid_reg;
    logic [79:0]          m_tdata_reg;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // truncating halves of sum and difference, offset to unsigned
    assign mid_sum   = 17'(signed'(s_tdata[15:0])) + 17'(signed'(s_tdata[31:16]));
    assign side_sum  = 17'(signed'(s_tdata[15:0])) - 17'(signed'(s_tdata[31:16]));
    assign mid_rnd   = mid_sum + {16'd0, mid_sum[16]};
    assign side_rnd  = side_sum + {16'd0, side_sum[16]};
    assign mid_half  = mid_rnd >>> 1;
    assign side_half = side_rnd >>> 1;
    assign mid_off   = {~mid_half[15], mid_half[14:0]};
    assign side_off  = {~side_half[15], side_half[14:0]};
    assign recip     = msh_pkg::RECIP_W'(msh_pkg::RECIP);
    assign rbin_in   = s_tdata[36:32];

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            mode_reg      <= s_tuser;
            mid_prod_reg  <= PW'(mid_off) * PW'(recip);
            side_prod_reg <= PW'(side_off) * PW'(recip);
            rbin_reg      <= (9'(rbin_in) >= 9'(msh_pkg::BINS)) ?
                             IW'(msh_pkg::BINS - 1) : IW'(rbin_in);
        end
    end

    // bin select: the read bin in read mode, else the quotient with clamp to the last bin
    assign mid_quo  = mid_prod_reg >> msh_pkg::RECIP_SHIFT;
    assign side_quo = side_prod_reg >> msh_pkg::RECIP_SHIFT;

    always_comb begin
        if (mode_reg == msh_pkg::MODE_READ) begin
            mid_idx_c  = rbin_reg;
            side_idx_c = rbin_reg;
        end else begin
            mid_idx_c  = (mid_quo >= PW'(msh_pkg::BINS)) ?
                         IW'(msh_pkg::BINS - 1) : IW'(mid_quo);
            side_idx_c = (side_quo >= PW'(msh_pkg::BINS)) ?
                         IW'(msh_pkg::BINS - 1) : IW'(side_quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == msh_pkg::ST_BIN) begin
            mid_idx_reg  <= mid_idx_c;
            side_idx_reg <= side_idx_c;
            mid_hit_reg  <= mid_vld_reg[mid_idx_c];
            side_hit_reg <= side_vld_reg[side_idx_c];
        end
    end

    msh_ram #(.WIDTH(CW), .DEPTH(msh_pkg::BINS)) u_mid_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (mid_idx_reg),
        .wr_data (mid_new),
        .rd_addr (mid_idx_c),
        .rd_data (mid_rd)
    );

    msh_ram #(.WIDTH(CW), .DEPTH(msh_pkg::BINS)) u_side_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (side_idx_reg),
        .wr_data (side_new),
        .rd_addr (side_idx_c),
        .rd_data (side_rd)
    );

    // saturating update
    assign mid_cur  = mid_hit_reg ? mid_rd : '0;
    assign side_cur = side_hit_reg ? side_rd : '0;
    assign mid_new  = (&mid_cur) ? mid_cur : mid_cur + CW'(1);
    assign side_new = (&side_cur) ? side_cur : side_cur + CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg  <= '0;
            side_vld_reg <= '0;
        end else if (wr_en) begin
            mid_vld_reg[mid_idx_reg]   <= 1'b1;
            side_vld_reg[side_idx_reg] <= 1'b1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msh_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = msh_pkg::ST_BIN;
                end
            end
            msh_pkg::ST_BIN: begin
                if (out_free) begin
                    state_next = msh_pkg::ST_RMW;
                end
            end
            msh_pkg::ST_RMW: begin
                state_next = msh_pkg::ST_IDLE;
            end
            default: begin
                state_next = msh_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        wr_en    = 1'b0;
        unique case (state_reg)
            msh_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            msh_pkg::ST_BIN: begin
                s_tready = 1'b0;
            end
            msh_pkg::ST_RMW: begin
                wr_en = (mode_reg == msh_pkg::MODE_ACCUM);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msh_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == msh_pkg::ST_RMW) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == msh_pkg::ST_RMW) begin
            m_tdata_reg[4:0]   <= 5'(mid_idx_reg);
            m_tdata_reg[9:5]   <= 5'(side_idx_reg);
            m_tdata_reg[41:10] <= (mode_reg == msh_pkg::MODE_READ) ? mid_cur : mid_new;
            m_tdata_reg[73:42] <= (mode_reg == msh_pkg::MODE_READ) ? side_cur : side_new;
            m_tdata_reg[79:74] <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_rmw_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msh_pkg::ST_RMW) |=> m_tvalid_reg)
        else $error("update step did not load the result register");

    a_read_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msh_pkg::ST_RMW && mode_reg == msh_pkg::MODE_READ) |-> !wr_en)
        else $error("bin read wrote the count memories");

    a_bin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[4:0] < 5'(msh_pkg::BINS)
                          && m_tdata_reg[9:5] < 5'(msh_pkg::BINS)))
        else $error("result bin out of range");

    a_no_update_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msh_pkg::ST_BIN && !out_free) |=> state_reg == msh_pkg::ST_BIN)
        else $error("update step entered with result register full");

endmodule

/* sim/tb_mid_side_histogram.sv */
`timescale 1ns / 100ps
// self-checking bench for mid_side_histogram: directed and random stream traffic against a bin tally model

module tb_mid_side_histogram;

    localparam int LIMIT_CYCLES = 200000;
    localparam int N_RANDOM     = 930;

    typedef struct packed {
        logic [msh_pkg::COUNT_W-1:0] side_count;
        logic [msh_pkg::COUNT_W-1:0] mid_count;
        logic [msh_pkg::FIELD_W-1:0] side_bin;
        logic [msh_pkg::FIELD_W-1:0] mid_bin;
    } bin_report_t;

    class bin_tally_model;
        logic [msh_pkg::COUNT_W-1:0] mid_tally [msh_pkg::BINS];
        logic [msh_pkg::COUNT_W-1:0] side_tally[msh_pkg::BINS];
        bin_report_t        due_results[$];
        int                 mismatches;
        int                 compared;
        int                 accums;
        int                 reads;

        function new();
            foreach (mid_tally[i]) begin
                mid_tally[i]  = '0;
                side_tally[i] = '0;
            end
            mismatches = 0;
            compared   = 0;
            accums     = 0;
            reads      = 0;
        endfunction

        function int unsigned amp_bin(int value);
            int unsigned idx;
            idx = int'(value + 32768) / msh_pkg::BIN_W;
            if (idx >= msh_pkg::BINS) begin
                idx = msh_pkg::BINS - 1;
            end
            return idx;
        endfunction

        function logic [msh_pkg::COUNT_W-1:0] bump(logic [msh_pkg::COUNT_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t ns: %s", $time, msg);
            end
        endfunction

        function void log_transfer(logic mode, logic signed [msh_pkg::SAMPLE_W-1:0] left_s,
                                   logic signed [msh_pkg::SAMPLE_W-1:0] right_s,
                                   logic [msh_pkg::FIELD_W-1:0] rb);
            bin_report_t exp_r;
            int          mid_v;
            int          side_v;
            int unsigned mb;
            int unsigned sb;
            if (mode == msh_pkg::MODE_ACCUM) begin
                // integer division truncates toward zero
                mid_v  = (int'(left_s) + int'(right_s)) / 2;
                side_v = (int'(left_s) - int'(right_s)) / 2;
                mb = amp_bin(mid_v);
                sb = amp_bin(side_v);
                mid_tally[mb]  = bump(mid_tally[mb]);
                side_tally[sb] = bump(side_tally[sb]);
                accums++;
            end else begin
                mb = (rb >= msh_pkg::BINS) ? msh_pkg::BINS - 1 : rb;
                sb = mb;
                reads++;
            end
            exp_r.mid_bin    = msh_pkg::FIELD_W'(mb);
            exp_r.side_bin   = msh_pkg::FIELD_W'(sb);
            exp_r.mid_count  = mid_tally[mb];
            exp_r.side_count = side_tally[sb];
            due_results.push_back(exp_r);
        endfunction

        function void check_transfer(logic [msh_pkg::M_TDATA_W-1:0] tdata);
            bin_report_t got;
            bin_report_t exp_r;
            got = tdata[$bits(bin_report_t)-1:0];
            if (due_results.size() == 0) begin
                flag($sformatf("unexpected result: mid_bin %0d side_bin %0d", got.mid_bin,
                               got.side_bin));
                return;
            end
            exp_r = due_results.pop_front();
            compared++;
            if (got.mid_bin !== exp_r.mid_bin) begin
                flag($sformatf("mid_bin exp %0d got %0d", exp_r.mid_bin, got.mid_bin));
            end
            if (got.side_bin !== exp_r.side_bin) begin
                flag($sformatf("side_bin exp %0d got %0d", exp_r.side_bin, got.side_bin));
            end
            if (got.mid_count !== exp_r.mid_count) begin
                flag($sformatf("mid_count bin %0d exp %0d got %0d", exp_r.mid_bin,
                               exp_r.mid_count, got.mid_count));
            end
            if (got.side_count !== exp_r.side_count) begin
                flag($sformatf("side_count bin %0d exp %0d got %0d", exp_r.side_bin,
                               exp_r.side_count, got.side_count));
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [msh_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [msh_pkg::M_TDATA_W-1:0] m_tdata;

    bin_tally_model                tally;
    bit                            tx_steady;
    bit                            rx_steady;
    int                            cycles;
    logic                          last_mode;
    logic [msh_pkg::SAMPLE_W-1:0]  last_left;
    logic [msh_pkg::SAMPLE_W-1:0]  last_right;
    logic [msh_pkg::FIELD_W-1:0]   last_rb;

    mid_side_histogram u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_mid_side_histogram: errors");
            $finish;
        end
    end

    function automatic logic [msh_pkg::SAMPLE_W-1:0] clip16(int v);
        if (v > 32767) begin
            return 16'h7FFF;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return msh_pkg::SAMPLE_W'(v);
    endfunction

    function automatic logic [msh_pkg::SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [msh_pkg::SAMPLE_W-1:0] left,
                             input logic [msh_pkg::SAMPLE_W-1:0] right,
                             input logic [msh_pkg::FIELD_W-1:0] rb);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, rb, right, left};
        do @(posedge aclk); while (!s_tready);
        tally.log_transfer(mode, left, right, rb);
        last_mode  = mode;
        last_left  = left;
        last_right = right;
        last_rb    = rb;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tally.due_results.size() != 0);
    endtask

    task automatic random_item();
        int          kind;
        int          edge_v;
        logic [15:0] a;
        logic [15:0] b;
        kind = $urandom_range(0, 99);
        a    = 16'($urandom());
        b    = 16'($urandom());
        if (kind < 15) begin
            send_item(msh_pkg::MODE_READ, a, b, 5'($urandom_range(0, 31)));
        end else if (kind < 50) begin
            send_item(msh_pkg::MODE_ACCUM, a, b, 5'($urandom()));
        end else if (kind < 65) begin
            send_item(msh_pkg::MODE_ACCUM, 16'($urandom_range(0, 6000) - 3000),
                      16'($urandom_range(0, 6000) - 3000), 5'($urandom()));
        end else if (kind < 75) begin
            send_item(msh_pkg::MODE_ACCUM, pick_extreme(), pick_extreme(), 5'($urandom()));
        end else if (kind < 85) begin
            // pairs whose mid or side lands on or next to a bin edge
            edge_v = $urandom_range(0, 29) * msh_pkg::BIN_W - 32768;
            if ($urandom_range(0, 1) == 0) begin
                send_item(msh_pkg::MODE_ACCUM, clip16(edge_v),
                          clip16(edge_v + $urandom_range(0, 4) - 2), 5'($urandom()));
            end else begin
                send_item(msh_pkg::MODE_ACCUM, clip16(edge_v),
                          clip16(-edge_v + $urandom_range(0, 4) - 2), 5'($urandom()));
            end
        end else begin
            send_item(last_mode, last_left, last_right, last_rb);
        end
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tally.check_transfer(m_tdata);
        end
    end

    initial begin
        tally      = new();
        tx_steady  = 1'b0;
        rx_steady  = 1'b0;
        last_mode  = msh_pkg::MODE_ACCUM;
        last_left  = '0;
        last_right = '0;
        last_rb    = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= msh_pkg::MODE_ACCUM;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, truncation toward zero, clamped top bins, back-to-back same bin
        send_item(msh_pkg::MODE_READ,  16'h1234, 16'hABCD, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h7FFF, 16'h7FFF, 5'd31);
        send_item(msh_pkg::MODE_ACCUM, 16'h8000, 16'h8000, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h7FFF, 16'h8000, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h8000, 16'h7FFF, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'hFFEF, 16'h0000, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h0000, 16'h0011, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'hFFFF, 16'h0000, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h0000, 16'h0000, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h5555, 16'hAAAA, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'hAAAA, 16'h5555, 5'd0);
        send_item(msh_pkg::MODE_ACCUM, 16'h7FFE, 16'h7FFF, 5'd0);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (4) send_item(msh_pkg::MODE_ACCUM, 16'h7FFF, 16'h7FFF, 5'd0);
        send_item(msh_pkg::MODE_READ,  16'hFFFF, 16'hFFFF, 5'd29);
        send_item(msh_pkg::MODE_ACCUM, 16'h7FFF, 16'h7FFF, 5'd0);
        send_item(msh_pkg::MODE_READ,  16'h0000, 16'h0000, 5'd29);
        send_item(msh_pkg::MODE_READ,  16'h8000, 16'h7FFF, 5'd15);
        send_item(msh_pkg::MODE_READ,  16'h7FFF, 16'h8000, 5'd30);
        send_item(msh_pkg::MODE_READ,  16'hFFFF, 16'h0000, 5'd31);
        send_item(msh_pkg::MODE_READ,  16'h0000, 16'hFFFF, 5'd1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 60 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if (i == N_RANDOM / 2) begin
                drain_results();
            end
            random_item();
        end
        s_tvalid <= 1'b0;

        while (tally.due_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d transfers: %0d pair accumulates, %0d bin reads",
                 tally.accums + tally.reads, tally.accums, tally.reads);
        $display("compared %0d results, %0d mismatches, %0d left waiting",
                 tally.compared, tally.mismatches, tally.due_results.size());
        if (tally.mismatches == 0 && tally.due_results.size() == 0) begin
            $display("tb_mid_side_histogram: clean");
        end else begin
            $display("tb_mid_side_histogram: errors");
        end
        $finish;
    end

endmodule

/* mid_side_histogram.f */
design/msh_pkg.sv
design/msh_ram.sv
design/mid_side_histogram.sv
sim/tb_mid_side_histogram.sv
